// ===== rtl/deq_pkg.sv =====
// Package for the double-ended queue: shared widths, op and status codes,
// and the control state type.
// No dependencies.
package deq_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_SEARCH     = 3'd6
    } deq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH
    } deq_state_t;

endpackage

// ===== rtl/deq_mem.sv =====
// Entry store of the queue: one write port, one read port, registered read.
// Depends on deq_pkg for the word width.
module deq_mem #(
    parameter int DEPTH  = deq_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(deq_pkg::CAPACITY_DEF)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [deq_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [deq_pkg::DATA_W-1:0] rd_data
);

    logic [deq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [deq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words in a ring store.
// Depends on deq_pkg and deq_mem.
//
// One item is worked on at a time; in_stall is high from acceptance until its
// result is loaded into the output register, so a new item can be taken while
// a result still waits there. Pushes answer from EXEC, pops and peeks from
// READ (the store read is registered), and a search compares entries from the
// front, up to the occupancy, as the single store read port delivers one entry
// per cycle while the output is not stalled. A full push or an empty
// pop/peek/search answers from EXEC. The store holds CAPACITY words; it needs
// no clearing after reset, since only written entries are ever read.
module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [deq_pkg::OP_W-1:0]            op,
    input  logic signed [deq_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [deq_pkg::DATA_W-1:0]   data,
    output logic                                found,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic [deq_pkg::OCC_W-1:0]           occupancy
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int OCC_W = deq_pkg::OCC_W;
    localparam int DATA_W = deq_pkg::DATA_W;

    localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    deq_pkg::deq_state_t  state_reg, state_next;
    deq_pkg::deq_op_t     op_reg, op_next;
    logic [DATA_W-1:0]    value_reg, value_next;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    logic                 found_reg, found_next;
    deq_pkg::deq_status_t status_reg, status_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;

    logic                 load_out;
    logic                 out_free;
    logic                 in_take;
    logic                 is_full;
    logic                 is_empty;
    logic                 hit;
    logic                 last;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [DATA_W-1:0]    rd_data;

    // position of the entry at a given offset from the front, offset <= CAPACITY
    function automatic logic [IDX_W-1:0] ring_pos(
        input logic [IDX_W-1:0] front,
        input logic [CNT_W-1:0] offset
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(offset);
        if (sum >= CAP_S)
        begin
            sum = sum - CAP_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    // low bits of a count as reported on occupancy
    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
        logic [OCC_W+CNT_W-1:0] ext;
        ext = {{OCC_W{1'b0}}, cnt};
        return ext[OCC_W-1:0];
    endfunction

    deq_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != deq_pkg::S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign is_full  = (count_reg == CAP_C);
    assign is_empty = (count_reg == '0);
    assign hit      = (rd_data == value_reg);
    assign last     = (idx_reg == count_reg - CNT_ONE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    case (op_reg)
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
                        deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK:
                        begin
                            state_next = is_empty ? deq_pkg::S_IDLE : deq_pkg::S_READ;
                        end
                        deq_pkg::OP_SEARCH:
                        begin
                            state_next = is_empty ? deq_pkg::S_IDLE : deq_pkg::S_SEARCH;
                        end
                        default:
                        begin
                            state_next = deq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            deq_pkg::S_READ:
            begin
                if (out_free)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            deq_pkg::S_SEARCH:
            begin
                if (out_free && (hit || last))
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, store accesses and result
    always_comb
    begin
        op_next     = op_reg;
        value_next  = value_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        load_out    = 1'b0;
        data_next   = '0;
        found_next  = 1'b0;
        status_next = deq_pkg::ST_OK;
        occ_next    = occ_of(count_reg);

        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = deq_pkg::deq_op_t'(op);
                    value_next = value;
                end
            end
            deq_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    case (op_reg)
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
                        begin
                            load_out = 1'b1;
                            if (is_full)
                            begin
                                status_next = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (op_reg == deq_pkg::OP_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? IDX_LAST
                                                                   : front_reg - IDX_W'(1);
                                    wr_addr    = front_next;
                                end
                                else
                                begin
                                    wr_addr = ring_pos(front_reg, count_reg);
                                end
                                count_next = count_reg + CNT_ONE;
                                occ_next   = occ_of(count_next);
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
                        deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK:
                        begin
                            if (is_empty)
                            begin
                                load_out    = 1'b1;
                                status_next = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                if (op_reg == deq_pkg::OP_POP_FRONT ||
                                    op_reg == deq_pkg::OP_PEEK_FRONT)
                                begin
                                    rd_addr = front_reg;
                                end
                                else
                                begin
                                    rd_addr = ring_pos(front_reg, count_reg - CNT_ONE);
                                end
                                // pointers move now; the word arrives next cycle
                                if (op_reg == deq_pkg::OP_POP_FRONT)
                                begin
                                    front_next = ring_pos(front_reg, CNT_ONE);
                                end
                                if (op_reg == deq_pkg::OP_POP_FRONT ||
                                    op_reg == deq_pkg::OP_POP_BACK)
                                begin
                                    count_next = count_reg - CNT_ONE;
                                end
                            end
                        end
                        deq_pkg::OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = front_reg;
                                idx_next = '0;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            deq_pkg::S_READ:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    data_next = rd_data;
                end
            end
            deq_pkg::S_SEARCH:
            begin
                if (out_free)
                begin
                    if (hit || last)
                    begin
                        load_out   = 1'b1;
                        found_next = hit;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_ONE;
                        rd_en    = 1'b1;
                        rd_addr  = ring_pos(front_reg, idx_next);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        if (load_out)
        begin
            data_reg   <= data_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule

// ===== tb/sv/tb_double_ended_queue.sv =====
// Self-checking testbench for double_ended_queue: directed corner items, then
// phased random traffic with bursty input and a stalling receiver.
// Depends on deq_pkg and the double_ended_queue RTL.
`timescale 1ns / 100ps

module tb_double_ended_queue;

    localparam int DATA_W       = deq_pkg::DATA_W;
    localparam int OP_W         = deq_pkg::OP_W;
    localparam int STATUS_W     = deq_pkg::STATUS_W;
    localparam int OCC_W        = deq_pkg::OCC_W;
    localparam int CAP          = deq_pkg::CAPACITY_DEF;
    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1050;
    localparam int PHASE_LEN    = 40;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;
    // bound for ~1100 items, leaving room for stalls and gaps
    localparam int TIMEOUT_NS   = 2_000_000;

    // op code outside the defined set; the block must answer it without effect
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occ;
    } deq_result_t;

    class deq_scoreboard;
        logic [DATA_W-1:0] ring [CAP];
        int unsigned       front_pos;
        int unsigned       stored;
        deq_result_t       awaited [$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       full_drops;
        int unsigned       empty_hits;
        int unsigned       search_hits;
        int unsigned       peak;

        function new();
            front_pos   = 0;
            stored      = 0;
            errors      = 0;
            checked     = 0;
            full_drops  = 0;
            empty_hits  = 0;
            search_hits = 0;
            peak        = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Apply one accepted item to the shadow deque and queue its answer.
        function void note_input(logic [OP_W-1:0] opc, logic [DATA_W-1:0] word);
            deq_result_t r;
            int unsigned i;
            r = '0;
            case (opc)
                deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
                begin
                    if (stored >= CAP)
                    begin
                        r.status = deq_pkg::ST_FULL;
                        full_drops++;
                    end
                    else
                    begin
                        if (opc == deq_pkg::OP_PUSH_FRONT)
                        begin
                            front_pos = (front_pos + CAP - 1) % CAP;
                            ring[front_pos] = word;
                        end
                        else
                            ring[(front_pos + stored) % CAP] = word;
                        stored++;
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT:
                begin
                    if (stored == 0)
                    begin
                        r.status = deq_pkg::ST_EMPTY;
                        empty_hits++;
                    end
                    else
                    begin
                        r.data = ring[front_pos];
                        if (opc == deq_pkg::OP_POP_FRONT)
                        begin
                            front_pos = (front_pos + 1) % CAP;
                            stored--;
                        end
                    end
                end
                deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK:
                begin
                    if (stored == 0)
                    begin
                        r.status = deq_pkg::ST_EMPTY;
                        empty_hits++;
                    end
                    else
                    begin
                        r.data = ring[(front_pos + stored - 1) % CAP];
                        if (opc == deq_pkg::OP_POP_BACK)
                            stored--;
                    end
                end
                deq_pkg::OP_SEARCH:
                begin
                    for (i = 0; i < stored; i++)
                        if (ring[(front_pos + i) % CAP] == word)
                            r.found = 1'b1;
                    if (r.found)
                        search_hits++;
                end
                default:
                    ;
            endcase
            r.occ = OCC_W'(stored);
            if (stored > peak)
                peak = stored;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] d, logic f,
                                   logic [STATUS_W-1:0] s, logic [OCC_W-1:0] o);
            deq_result_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result data=%h found=%b status=%0d occ=%0d",
                             $time, d, f, s, o);
                return;
            end
            want = awaited.pop_front();
            if (d !== want.data || f !== want.found || s !== want.status || o !== want.occ)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: result %0d expected data=%h found=%b status=%0d occ=%0d",
                             $time, checked, want.data, want.found, want.status, want.occ);
                    $display("%0t: result %0d actual   data=%h found=%b status=%0d occ=%0d",
                             $time, checked, d, f, s, o);
                end
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [OP_W-1:0]            op;
    logic signed [DATA_W-1:0]   value;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DATA_W-1:0]   data;
    logic                       found;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;

    deq_scoreboard sb = new();

    // sender-side bookkeeping
    int unsigned       burst_left = 0;
    int unsigned       items_sent = 0;
    logic [DATA_W-1:0] recent_words [CAP];
    int unsigned       recent_wr = 0;
    bit                hold_req = 1'b0;

    double_ended_queue #(.CAPACITY(CAP)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .found     (found),
        .status    (status),
        .occupancy (occupancy)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(data, found, status, occupancy);
            if (in_valid && !in_stall)
                sb.note_input(op, value);
        end
    end

    // Offer one item and hold it until taken; opens a new burst with a random gap,
    // possibly none, in front of it when the current burst is used up.
    task automatic send_item(input logic [OP_W-1:0] opc, input logic [DATA_W-1:0] word);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        op       <= opc;
        value    <= word;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (opc == deq_pkg::OP_PUSH_FRONT || opc == deq_pkg::OP_PUSH_BACK)
        begin
            recent_words[recent_wr] = word;
            recent_wr = (recent_wr + 1) % CAP;
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5:    return DATA_W'($urandom_range(0, 15)); // small: repeats likely
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int unsigned push_pct,
                                                input int unsigned search_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_UNUSED;
        if (r < 2 + push_pct)
            return ($urandom_range(0, 1) != 0) ? deq_pkg::OP_PUSH_BACK
                                               : deq_pkg::OP_PUSH_FRONT;
        if (r < 2 + push_pct + search_pct)
            return deq_pkg::OP_SEARCH;
        case ($urandom_range(0, 3))
            0:       return deq_pkg::OP_POP_FRONT;
            1:       return deq_pkg::OP_POP_BACK;
            2:       return deq_pkg::OP_PEEK_FRONT;
            default: return deq_pkg::OP_PEEK_BACK;
        endcase
    endfunction

    // receiver: stall pattern changes every stretch, plus one long hold-off
    initial
    begin
        int unsigned mode;
        int unsigned stretch;
        bit          stall_now;
        out_stall = 1'b0;
        mode      = 0;
        stretch   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 4);
                    stretch = $urandom_range(5, 60);
                end
                stretch--;
                case (mode)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 3) == 0);
                    2:       stall_now = ($urandom_range(0, 9) < 6);
                    3:       stall_now = stretch[0];
                    default: stall_now = ($urandom_range(0, 7) < 2);
                endcase
                out_stall <= stall_now;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout: items still outstanding at %0t", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned       n;
        int unsigned       push_pct;
        int unsigned       search_pct;
        logic [OP_W-1:0]   opc;
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] edge_words [4];

        edge_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = deq_pkg::OP_PUSH_FRONT;
        value    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque: every read op must report empty, search must miss
        send_item(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_item(deq_pkg::OP_POP_BACK, 32'hffff_ffff);
        send_item(deq_pkg::OP_PEEK_BACK, 32'h0000_0000);
        send_item(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000);
        send_item(deq_pkg::OP_SEARCH, 32'h0000_0000);
        // fill to capacity from both ends
        for (n = 0; n < CAP; n++)
            send_item(n[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                      (n < 4) ? edge_words[n] : $urandom());
        send_item(OP_UNUSED, 32'h1234_5678);
        send_item(deq_pkg::OP_PUSH_FRONT, 32'h5a5a_5a5a);
        send_item(deq_pkg::OP_PUSH_BACK, 32'ha5a5_a5a5);
        send_item(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000);
        send_item(deq_pkg::OP_PEEK_BACK, 32'h0000_0000);
        send_item(deq_pkg::OP_SEARCH, 32'h7fff_ffff);
        send_item(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_item(deq_pkg::OP_POP_BACK, 32'h0000_0000);

        push_pct   = 40;
        search_pct = 15;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // each phase is picked at random from filling, draining, mixed and search-heavy
            if (n % PHASE_LEN == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        push_pct   = 70;
                        search_pct = 10;
                    end
                    1:
                    begin
                        push_pct   = 15;
                        search_pct = 10;
                    end
                    2:
                    begin
                        push_pct   = 40;
                        search_pct = 15;
                    end
                    default:
                    begin
                        push_pct   = 35;
                        search_pct = 40;
                    end
                endcase
            end
            if (n == 300)
                hold_req = 1'b1;
            if (n == 600)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            opc = pick_op(push_pct, search_pct);
            if (opc == deq_pkg::OP_SEARCH && $urandom_range(0, 1) != 0)
                word = recent_words[$urandom_range(0, CAP - 1)];
            else
                word = pick_word();
            send_item(opc, word);
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d items, %0d results checked; peak occupancy %0d of %0d.",
                 items_sent, sb.checked, sb.peak, CAP);
        $display("Full pushes dropped %0d, empty reads %0d, search hits %0d, mismatches %0d.",
                 sb.full_drops, sb.empty_hits, sb.search_hits, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/deq_pkg.sv
rtl/deq_mem.sv
rtl/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
